[sv/phl_pkg.sv]
// phl_pkg: types, codes and sizes for the peer heartbeat liveness table
// no dependencies
`default_nettype none
package phl_pkg;

  localparam int PEER_ENTRIES_DEF = 16;
  localparam int MAX_RESULTS      = 32;
  localparam int CNT_W            = 6;
  localparam int TIMER_W          = 20;

  localparam logic [2:0] OP_REGISTER    = 3'd0;
  localparam logic [2:0] OP_REMOTE_DISC = 3'd1;
  localparam logic [2:0] OP_HEARTBEAT   = 3'd2;
  localparam logic [2:0] OP_TICK        = 3'd3;
  localparam logic [2:0] OP_LOCAL_DISC  = 3'd4;
  localparam logic [2:0] OP_FLUSH       = 3'd5;

  localparam logic [3:0] EV_NONE         = 4'd0;
  localparam logic [3:0] EV_FOUND        = 4'd1;
  localparam logic [3:0] EV_RECONNECTED  = 4'd2;
  localparam logic [3:0] EV_CHANGED      = 4'd3;
  localparam logic [3:0] EV_DISCONNECTED = 4'd4;
  localparam logic [3:0] EV_LOST         = 4'd5;
  localparam logic [3:0] EV_SEND_HB      = 4'd6;
  localparam logic [3:0] EV_UNKNOWN      = 4'd7;
  localparam logic [3:0] EV_FULL         = 4'd8;
  localparam logic [3:0] EV_SEND_DISC    = 4'd9;

  localparam logic REG_HB_ENABLE = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_PASS0, S_EV1, S_PASS1, S_EV2, S_DONE
  } st_t;

  typedef struct packed {
    logic                 valid;
    logic [31:0]          addr;
    logic [31:0]          tag;
    logic                 lost;
    logic                 send_act;
    logic [TIMER_W-1:0]   send_el;
    logic [15:0]          send_per;
    logic                 recv_act;
    logic [TIMER_W-1:0]   recv_el;
    logic [15:0]          recv_lim;
  } entry_t;

  function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t,
                                                 input logic [15:0] ms);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + {{(TIMER_W-15){1'b0}}, ms};
    return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/phl_if.sv]
// phl_in_if, phl_out_if: valid/ready channels of the liveness table
// no dependencies
`default_nettype none
interface phl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] peer_address;
  logic [31:0] property_tag;
  logic        wants_heartbeat;
  logic [15:0] send_interval_ms;
  logic [15:0] elapsed_ms;
  modport source (output valid, op, peer_address, property_tag, wants_heartbeat,
                  send_interval_ms, elapsed_ms, input ready);
  modport sink (input valid, op, peer_address, property_tag, wants_heartbeat,
                send_interval_ms, elapsed_ms, output ready);
  modport mon (input valid, ready, op, peer_address, property_tag, wants_heartbeat,
               send_interval_ms, elapsed_ms);
endinterface

interface phl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [31:0] event_address;
  logic        last;
  modport source (output valid, event_res, event_address, last, input ready);
  modport sink (input valid, event_res, event_address, last, output ready);
  modport mon (input valid, ready, event_res, event_address, last);
endinterface
`default_nettype wire

[sv/phl_cell.sv]
// phl_cell: one peer entry of the rotating table
// depends on phl_pkg
`default_nettype none
module phl_cell
  import phl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   shift,
  input  wire entry_t d,
  output entry_t      q
);
  entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid    <= 1'b0;
      q_r.lost     <= 1'b0;
      q_r.send_act <= 1'b0;
      q_r.recv_act <= 1'b0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

[sv/peer_heartbeat_liveness_table.sv]
// peer_heartbeat_liveness_table: ring of entry cells with a sequencer at the head
// depends on phl_pkg, phl_if, phl_cell
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        op, address, tag, wants, interval, elapsed
//  out_ch   out  valid/ready        event_res, event_address, last
//  cfg      in   cfg_we, no ready   cfg_idx, cfg_data
//
// an item makes two full turns of the cell ring, one entry passing the head
// per cycle unless a stalled output holds it, plus event and closing steps
// the input is taken only between items; a stalled output holds the ring
// reset clears all entries at once, no clearing pass
`default_nettype none
module peer_heartbeat_liveness_table
  import phl_pkg::*;
#(
  parameter int PEER_ENTRIES = PEER_ENTRIES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  phl_in_if.sink     in_ch,
  phl_out_if.source  out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [15:0] cfg_data
);
  localparam int IW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(PEER_ENTRIES - 1);

  entry_t cq [PEER_ENTRIES];
  entry_t head, nhead;
  logic   ring_shift;

  st_t st_r, st_nxt;
  logic [IW-1:0] cnt_r;
  logic [2:0]  op_r;
  logic [31:0] addr_r, tag_r;
  logic        wants_r;
  logic [15:0] per_r, ms_r;
  logic        hb_en_r;
  logic [15:0] tmo_r;

  logic          found_r, flost_r, ftagne_r, fra_r, free_r;
  logic [IW-1:0] fidx_r, freeidx_r;
  logic [CNT_W-1:0] n_r;

  logic        pend_v_r;
  logic [3:0]  pend_ev_r;
  logic [31:0] pend_addr_r;
  logic        out_v_r, out_last_r;
  logic [3:0]  out_ev_r;
  logic [31:0] out_addr_r;

  logic        ev_v, ev_ok, can_push, stall, adv, lookup, apply, at_tgt, out_load;
  logic [3:0]  ev_code;
  logic [31:0] ev_addr;
  logic [IW-1:0] tgt;
  logic [TIMER_W-1:0] s_sum;

  genvar g;
  generate
    for (g = 0; g < PEER_ENTRIES; g++) begin : g_cell
      entry_t dn;
      if (g == PEER_ENTRIES - 1) begin : g_tail
        assign dn = nhead;
      end else begin : g_mid
        assign dn = cq[g+1];
      end
      phl_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(ring_shift), .d(dn), .q(cq[g]));
    end
  endgenerate

  assign head     = cq[0];
  assign lookup   = (op_r == OP_REGISTER) || (op_r == OP_REMOTE_DISC) ||
                    (op_r == OP_HEARTBEAT) || (op_r == OP_LOCAL_DISC);
  assign tgt      = found_r ? fidx_r : freeidx_r;
  assign at_tgt   = (cnt_r == tgt);
  assign can_push = !out_v_r || out_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);

  always_comb begin
    case (op_r)
      OP_REGISTER:    apply = found_r || free_r;
      OP_REMOTE_DISC: apply = found_r;
      OP_LOCAL_DISC:  apply = found_r;
      OP_HEARTBEAT:   apply = found_r && fra_r;
      default:        apply = 1'b0;
    endcase
  end

  always_comb begin
    nhead   = head;
    ev_v    = 1'b0;
    ev_code = EV_NONE;
    ev_addr = addr_r;
    s_sum   = '0;
    case (st_r)
      S_PASS0: begin
        if (op_r == OP_TICK && head.send_act) begin
          s_sum = sat_add(head.send_el, ms_r);
          if (s_sum >= {{(TIMER_W-16){1'b0}}, head.send_per}) begin
            ev_v    = 1'b1;
            ev_code = EV_SEND_HB;
            ev_addr = head.addr;
            nhead.send_el = s_sum - {{(TIMER_W-16){1'b0}}, head.send_per};
          end else begin
            nhead.send_el = s_sum;
          end
        end
      end
      S_EV1: begin
        case (op_r)
          OP_REGISTER: begin
            ev_v = 1'b1;
            if (found_r) begin
              if (flost_r) ev_code = EV_RECONNECTED;
              else if (ftagne_r) ev_code = EV_CHANGED;
              else ev_v = 1'b0;
            end else begin
              ev_code = free_r ? EV_FOUND : EV_FULL;
            end
          end
          OP_REMOTE_DISC, OP_LOCAL_DISC: begin
            ev_v    = 1'b1;
            ev_code = found_r ? EV_DISCONNECTED : EV_UNKNOWN;
          end
          OP_HEARTBEAT: begin
            if (!found_r || !fra_r) begin
              ev_v    = 1'b1;
              ev_code = EV_UNKNOWN;
            end else if (flost_r) begin
              ev_v    = 1'b1;
              ev_code = EV_RECONNECTED;
            end
          end
          default: ev_v = 1'b0;
        endcase
      end
      S_PASS1: begin
        if (op_r == OP_TICK) begin
          if (hb_en_r && head.recv_act) begin
            nhead.recv_el = sat_add(head.recv_el, ms_r);
            if (nhead.recv_el >= {{(TIMER_W-16){1'b0}}, head.recv_lim} &&
                head.valid && !head.lost) begin
              nhead.lost = 1'b1;
              ev_v       = 1'b1;
              ev_code    = EV_LOST;
              ev_addr    = head.addr;
            end
          end
        end else if (op_r == OP_FLUSH) begin
          nhead.valid    = 1'b0;
          nhead.lost     = 1'b0;
          nhead.send_act = 1'b0;
          nhead.recv_act = 1'b0;
        end else if (apply && at_tgt) begin
          case (op_r)
            OP_REGISTER: begin
              nhead.tag  = tag_r;
              nhead.lost = 1'b0;
              if (!found_r) begin
                nhead.valid    = 1'b1;
                nhead.addr     = addr_r;
                nhead.send_act = 1'b0;
                nhead.recv_act = 1'b0;
              end
              if (hb_en_r) begin
                nhead.recv_act = 1'b1;
                nhead.recv_el  = '0;
                nhead.recv_lim = tmo_r;
              end
              if (wants_r) begin
                nhead.send_act = 1'b1;
                nhead.send_el  = '0;
                nhead.send_per = per_r;
              end
            end
            OP_REMOTE_DISC, OP_LOCAL_DISC: begin
              nhead.valid    = 1'b0;
              nhead.lost     = 1'b0;
              nhead.send_act = 1'b0;
              nhead.recv_act = 1'b0;
            end
            OP_HEARTBEAT: begin
              nhead.recv_el = '0;
              nhead.lost    = 1'b0;
            end
            default: nhead = head;
          endcase
        end
      end
      S_EV2: begin
        if (op_r == OP_REGISTER && apply && wants_r) begin
          ev_v    = 1'b1;
          ev_code = EV_SEND_HB;
        end else if (op_r == OP_LOCAL_DISC && found_r) begin
          ev_v    = 1'b1;
          ev_code = EV_SEND_DISC;
        end
      end
      default: ev_v = 1'b0;
    endcase
  end

  assign ev_ok      = ev_v && (n_r < CNT_W'(MAX_RESULTS));
  assign stall      = ev_ok && pend_v_r && !can_push;
  assign adv        = !stall;
  assign ring_shift = ((st_r == S_PASS0) || (st_r == S_PASS1)) && adv;
  assign out_load   = (ev_ok && adv && pend_v_r) || ((st_r == S_DONE) && can_push);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_ch.valid) st_nxt = S_PASS0;
      S_PASS0: if (adv && cnt_r == LAST_IDX) st_nxt = S_EV1;
      S_EV1:   if (adv) st_nxt = S_PASS1;
      S_PASS1: if (adv && cnt_r == LAST_IDX) st_nxt = S_EV2;
      S_EV2:   if (adv) st_nxt = S_DONE;
      S_DONE:  if (can_push) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cnt_r   <= '0;
      hb_en_r <= 1'b1;
      tmo_r   <= 16'd3000;
      n_r     <= '0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_idx == REG_HB_ENABLE) hb_en_r <= cfg_data[0];
        else tmo_r <= cfg_data;
      end
      if (ring_shift) cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
      if (out_load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;

      if (st_r == S_IDLE && in_ch.valid) begin
        op_r    <= in_ch.op;
        addr_r  <= in_ch.peer_address;
        tag_r   <= in_ch.property_tag;
        wants_r <= in_ch.wants_heartbeat;
        per_r   <= in_ch.send_interval_ms;
        ms_r    <= in_ch.elapsed_ms;
        found_r <= 1'b0;
        free_r  <= 1'b0;
        n_r     <= '0;
        cnt_r   <= '0;
      end

      if (st_r == S_PASS0 && ring_shift && lookup) begin
        if (!found_r && head.valid && head.addr == addr_r) begin
          found_r  <= 1'b1;
          fidx_r   <= cnt_r;
          flost_r  <= head.lost;
          ftagne_r <= (head.tag != tag_r);
          fra_r    <= head.recv_act;
        end
        if (!free_r && !head.valid) begin
          free_r    <= 1'b1;
          freeidx_r <= cnt_r;
        end
      end

      if (ev_ok && adv) begin
        n_r         <= n_r + 1'b1;
        pend_v_r    <= 1'b1;
        pend_ev_r   <= ev_code;
        pend_addr_r <= ev_addr;
        if (pend_v_r) begin
          out_ev_r   <= pend_ev_r;
          out_addr_r <= pend_addr_r;
          out_last_r <= 1'b0;
        end
      end

      if (st_r == S_DONE && can_push) begin
        pend_v_r   <= 1'b0;
        out_last_r <= 1'b1;
        out_ev_r   <= pend_v_r ? pend_ev_r : EV_NONE;
        out_addr_r <= pend_v_r ? pend_addr_r : 32'd0;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.event_res     = out_ev_r;
  assign out_ch.event_address = out_addr_r;
  assign out_ch.last          = out_last_r;
endmodule
`default_nettype wire

[tb/phl_checker.sv]
// phl_checker: watches both channels, predicts the event stream of the liveness table
// and compares it beat by beat; depends on phl_pkg and phl_if
`default_nettype none
module phl_checker
  import phl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  phl_in_if.mon     in_mon,
  phl_out_if.mon    out_mon,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending_events,
  output int               beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  ev;
    logic [31:0] addr;
    logic        last;
  } event_t;

  event_t expected_events[$];
  event_t burst[$];

  logic        hb_enable;
  logic [15:0] rx_timeout;
  logic        pv[16];
  logic [31:0] paddr[16];
  logic [31:0] ptag[16];
  logic        plost[16];
  logic        tx_on[16];
  logic [19:0] tx_el[16];
  logic [15:0] tx_per[16];
  logic        rx_on[16];
  logic [19:0] rx_el[16];
  logic [15:0] rx_lim[16];

  function automatic logic [19:0] timer_add(logic [19:0] t, logic [15:0] ms);
    logic [20:0] s;
    s = {1'b0, t} + {5'd0, ms};
    return s[20] ? 20'hFFFFF : s[19:0];
  endfunction

  function automatic int lookup(logic [31:0] a);
    for (int i = 0; i < 16; i++)
      if (pv[i] && paddr[i] == a) return i;
    return -1;
  endfunction

  function automatic void push_event(logic [3:0] ev, logic [31:0] a);
    event_t e;
    if (burst.size() >= MAX_RESULTS) return;
    e.ev = ev;
    e.addr = a;
    e.last = 1'b0;
    burst = {burst, e};
  endfunction

  task automatic predict_events(logic [2:0] op, logic [31:0] a, logic [31:0] tag,
                                logic wants, logic [15:0] per, logic [15:0] ms);
    int i;
    int k;
    burst.delete();
    case (op)
      OP_REGISTER: begin
        i = lookup(a);
        if (i < 0) begin
          k = 0;
          while (k < 16 && pv[k]) k++;
          if (k == 16) push_event(EV_FULL, a);
          else begin
            i = k;
            pv[i] = 1; paddr[i] = a; ptag[i] = tag;
            plost[i] = 0; tx_on[i] = 0; rx_on[i] = 0;
            push_event(EV_FOUND, a);
          end
        end else if (plost[i]) begin
          ptag[i] = tag; plost[i] = 0;
          push_event(EV_RECONNECTED, a);
        end else if (ptag[i] != tag) begin
          ptag[i] = tag;
          push_event(EV_CHANGED, a);
        end
        if (i >= 0) begin
          if (hb_enable) begin
            rx_on[i] = 1; rx_el[i] = 0; rx_lim[i] = rx_timeout;
          end
          if (wants) begin
            tx_on[i] = 1; tx_el[i] = 0; tx_per[i] = per;
            push_event(EV_SEND_HB, a);
          end
        end
      end
      OP_REMOTE_DISC, OP_LOCAL_DISC: begin
        i = lookup(a);
        if (i < 0) push_event(EV_UNKNOWN, a);
        else begin
          pv[i] = 0; plost[i] = 0; tx_on[i] = 0; rx_on[i] = 0;
          push_event(EV_DISCONNECTED, a);
          if (op == OP_LOCAL_DISC) push_event(EV_SEND_DISC, a);
        end
      end
      OP_HEARTBEAT: begin
        i = lookup(a);
        if (i < 0 || !rx_on[i]) push_event(EV_UNKNOWN, a);
        else begin
          rx_el[i] = 0;
          if (plost[i]) begin
            plost[i] = 0;
            push_event(EV_RECONNECTED, a);
          end
        end
      end
      OP_TICK: begin
        for (int j = 0; j < 16; j++) begin
          if (!tx_on[j]) continue;
          tx_el[j] = timer_add(tx_el[j], ms);
          if (tx_el[j] >= {4'd0, tx_per[j]}) begin
            push_event(EV_SEND_HB, paddr[j]);
            tx_el[j] = tx_el[j] - {4'd0, tx_per[j]};
          end
        end
        if (hb_enable)
          for (int j = 0; j < 16; j++) begin
            if (!rx_on[j]) continue;
            rx_el[j] = timer_add(rx_el[j], ms);
            if (rx_el[j] >= {4'd0, rx_lim[j]} && pv[j] && !plost[j]) begin
              plost[j] = 1;
              push_event(EV_LOST, paddr[j]);
            end
          end
      end
      OP_FLUSH: begin
        for (int j = 0; j < 16; j++) begin
          pv[j] = 0; plost[j] = 0; tx_on[j] = 0; rx_on[j] = 0;
        end
      end
      default: ;
    endcase
    if (burst.size() == 0) push_event(EV_NONE, 32'd0);
    burst[burst.size()-1].last = 1'b1;
    foreach (burst[n]) expected_events = {expected_events, burst[n]};
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    event_t e;
    if (!rst_n) begin
      hb_enable <= 1'b1;
      rx_timeout <= 16'd3000;
      fail_count = 0;
      beats_seen = 0;
      expected_events.delete();
      for (int j = 0; j < 16; j++) begin
        pv[j] = 0; plost[j] = 0; tx_on[j] = 0; rx_on[j] = 0;
        paddr[j] = 0; ptag[j] = 0; tx_el[j] = 0; tx_per[j] = 0;
        rx_el[j] = 0; rx_lim[j] = 0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_HB_ENABLE) hb_enable <= cfg_data[0];
        else rx_timeout <= cfg_data;
      end
      if (in_mon.valid && in_mon.ready)
        predict_events(in_mon.op, in_mon.peer_address, in_mon.property_tag,
                       in_mon.wants_heartbeat, in_mon.send_interval_ms, in_mon.elapsed_ms);
      if (out_mon.valid && out_mon.ready) begin
        beats_seen++;
        if (expected_events.size() == 0) begin
          report("unexpected beat", {28'd0, out_mon.event_res}, 32'd0);
        end else begin
          e = expected_events.pop_front();
          if (out_mon.event_res !== e.ev) report("event_res", out_mon.event_res, e.ev);
          if (out_mon.event_address !== e.addr) report("event_address", out_mon.event_address, e.addr);
          if (out_mon.last !== e.last) report("last", out_mon.last, e.last);
        end
      end
    end
    pending_events = expected_events.size();
  end
endmodule
`default_nettype wire

[tb/testbench.sv]
// testbench: stimulus, configuration phases and verdict for the liveness table
// depends on phl_pkg, phl_if, phl_checker and the block itself
`default_nettype none
module testbench;
  import phl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending_events;
  int          beats_seen;
  int          items_sent;
  int          idle_cycles;
  logic [31:0] pool[8];

  phl_in_if  in_ch();
  phl_out_if out_ch();

  peer_heartbeat_liveness_table DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  phl_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.mon), .out_mon(out_ch.mon),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_events(pending_events), .beats_seen(beats_seen)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall per beat, with quiet stretches
  initial begin
    int w;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.ready && out_ch.valid) begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (w > 0) begin
          out_ch.ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end else if (!out_ch.ready && rst_n) out_ch.ready <= 1'b1;
    end
  end

  // stall watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [31:0] a, logic [31:0] tag,
                           logic wants, logic [15:0] per, logic [15:0] ms, bit gap);
    int w;
    w = gap ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15)) : 0;
    if (w > 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.peer_address <= a;
    in_ch.property_tag <= tag;
    in_ch.wants_heartbeat <= wants;
    in_ch.send_interval_ms <= per;
    in_ch.elapsed_ms <= ms;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic drain_block;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (2 * PEER_ENTRIES_DEF + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item;
    logic [2:0]  op;
    logic [31:0] a;
    int          r;
    r = $urandom_range(0, 99);
    a = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
    if (r < 30) op = OP_REGISTER;
    else if (r < 40) op = OP_REMOTE_DISC;
    else if (r < 60) op = OP_HEARTBEAT;
    else if (r < 88) op = OP_TICK;
    else if (r < 95) op = OP_LOCAL_DISC;
    else if (r < 97) op = OP_FLUSH;
    else op = 3'($urandom_range(6, 7));
    send_item(op, a, ($urandom_range(0, 1) ? 32'h5A5A0000 : $urandom()),
              1'($urandom()), 16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 4000)),
              16'($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 2000)), 1'b1);
  endtask

  initial begin
    items_sent = 0;
    rst_n = 0;
    cfg_we = 0; cfg_idx = 0; cfg_data = 0;
    in_ch.valid = 0; in_ch.op = OP_FLUSH; in_ch.peer_address = 0; in_ch.property_tag = 0;
    in_ch.wants_heartbeat = 0; in_ch.send_interval_ms = 0; in_ch.elapsed_ms = 0;
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_HB_ENABLE, 16'd1);

    // directed: lifecycle, extremes and the special cases
    send_item(OP_REGISTER, 32'h0, 32'h0, 1'b1, 16'd0, 16'd0, 1'b0);
    send_item(OP_REGISTER, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 16'hFFFF, 16'd0, 1'b0);
    send_item(OP_REGISTER, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 16'd1, 16'd0, 1'b0);
    send_item(OP_REGISTER, 32'hFFFFFFFF, 32'h12345678, 1'b0, 16'd1, 16'd0, 1'b0);
    send_item(OP_TICK, 32'h0, 32'h0, 1'b0, 16'd0, 16'hFFFF, 1'b0);
    send_item(OP_TICK, 32'h0, 32'h0, 1'b0, 16'd0, 16'hFFFF, 1'b0);
    send_item(OP_HEARTBEAT, 32'h0, 32'h0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_REGISTER, 32'hFFFFFFFF, 32'h1, 1'b1, 16'd5, 16'd0, 1'b0);
    send_item(OP_HEARTBEAT, 32'hDEADBEEF, 32'h0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_REMOTE_DISC, 32'hDEADBEEF, 32'h0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_LOCAL_DISC, 32'h0, 32'h0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_REMOTE_DISC, 32'hFFFFFFFF, 32'h0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(3'd6, 32'h1, 32'h1, 1'b1, 16'd1, 16'd1, 1'b0);
    send_item(3'd7, 32'h1, 32'h1, 1'b1, 16'd1, 16'd1, 1'b0);
    // fill the table past full, each wanting a heartbeat, then one tick that reaches the result limit
    for (int i = 0; i < 17; i++)
      send_item(OP_REGISTER, 32'hA0000000 + i, 32'(i), 1'b1, 16'd0, 16'd0, 1'b1);
    send_item(OP_TICK, 32'h0, 32'h0, 1'b0, 16'd0, 16'd10, 1'b0);
    send_item(OP_FLUSH, 32'h0, 32'h0, 1'b0, 16'd0, 16'd0, 1'b0);
    drain_block();

    // heartbeat watching off, then back on with the largest timeout
    write_reg(REG_HB_ENABLE, 16'd0);
    for (int i = 0; i < 80; i++) random_item();
    drain_block();
    write_reg(REG_HB_ENABLE, 16'd1);
    write_reg(REG_TIMEOUT, 16'hFFFF);
    for (int i = 0; i < 80; i++) random_item();
    drain_block();
    write_reg(REG_TIMEOUT, 16'($urandom_range(100, 3000)));
    for (int i = 0; i < 80; i++) random_item();
    drain_block();

    $display("covered %0d input items and %0d result beats over four register settings",
             items_sent, beats_seen);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
sv/phl_pkg.sv
sv/phl_if.sv
sv/phl_cell.sv
sv/peer_heartbeat_liveness_table.sv
tb/phl_checker.sv
tb/testbench.sv
